// File: rtl/sha256_pkg.sv
// SHA-256 package: constants, queue entry type, rotate-right function, sequencer states.
package sha256_pkg;

    // Round constants.
    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_LIMIT = 6'd56;

    // One filled block handed from the front to the back.
    typedef struct packed {
        logic [511:0] block;   // word 0 in the top bits
        logic         final_blk; // emit digest after this block
    } t_blk;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_core_st;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// File: rtl/sha256_front.sv
// Front end: packs message bytes into blocks, appends padding and length.
module sha256_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_byte,
    input  logic                i_byte_valid,
    input  logic                i_last,
    output logic                o_blk_valid,
    input  logic                i_blk_ready,
    output sha256_pkg::t_blk    o_blk
);

    localparam logic [7:0] PAD_W = sha256_pkg::PAD_BYTE;

    // 0x80 at byte fill, zeros after it.
    function automatic logic [511:0] pad_tail(input logic [511:0] b, input logic [5:0] f);
        logic [511:0] m;
        logic [511:0] r;
        m = {512{1'b1}} << (10'd512 - {f, 3'b000});
        if (f == 6'd0) m = '0;
        r = b & m;
        r[511 - {f, 3'b000} -: 8] = PAD_W;
        return r;
    endfunction

    // Padding phases: take bytes, push extra pad block, push length block.
    logic [511:0] r_buf;
    logic [5:0]   r_fill;
    logic [63:0]  r_bits;
    logic         r_busy;       // holding a block to push
    logic         r_blk_final;
    logic         r_need_len;   // a length-only block follows
    logic         r_need_pad;   // padding still to append (block filled by last byte)

    logic [511:0] n_buf;
    logic [5:0]   n_fill;
    logic [63:0]  n_bits;
    logic [511:0] pad_buf;
    logic         take;

    assign o_ready     = !r_busy;
    assign take        = i_valid && o_ready;
    assign o_blk_valid = r_busy;
    assign o_blk       = '{block: r_buf, final_blk: r_blk_final};
    assign pad_buf     = pad_tail(n_buf, n_fill);

    // Byte placement, padding and length on the accepted item.
    always_comb begin
        logic [511:0] b;
        logic [5:0]   f;
        logic [63:0]  c;
        b = r_buf;
        f = r_fill;
        c = r_bits;
        if (i_byte_valid) begin
            b[511 - {f, 3'b000} -: 8] = i_byte;
            c = c + 64'd8;
            f = f + 6'd1;
        end
        n_buf  = b;
        n_fill = f;
        n_bits = c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_bits      <= '0;
            r_busy      <= 1'b0;
            r_blk_final <= 1'b0;
            r_need_len  <= 1'b0;
            r_need_pad  <= 1'b0;
        end else if (r_busy) begin
            if (i_blk_ready) begin
                if (r_need_pad) begin
                    // block filled by the last byte: padding block with length
                    r_buf       <= {PAD_W, 440'd0, r_bits};
                    r_blk_final <= 1'b1;
                    r_need_pad  <= 1'b0;
                    r_bits      <= '0;
                end else if (r_need_len) begin
                    r_buf       <= {448'd0, r_bits};
                    r_blk_final <= 1'b1;
                    r_need_len  <= 1'b0;
                    r_bits      <= '0;
                end else begin
                    r_busy      <= 1'b0;
                    r_blk_final <= 1'b0;
                end
            end
        end else if (take) begin
            if (i_byte_valid && n_fill == 6'd0) begin
                r_bits     <= n_bits;
                r_fill     <= n_fill;
                r_buf      <= n_buf;
                r_busy     <= 1'b1;
                r_need_pad <= i_last;
            end else if (i_last) begin
                r_fill <= '0;
                r_busy <= 1'b1;
                if (n_fill >= sha256_pkg::LEN_LIMIT) begin
                    r_bits     <= n_bits;
                    r_buf      <= pad_buf;
                    r_need_len <= 1'b1;
                end else begin
                    r_buf       <= {pad_buf[511:64], n_bits};
                    r_blk_final <= 1'b1;
                    r_bits      <= '0;
                end
            end else begin
                r_bits <= n_bits;
                r_fill <= n_fill;
                r_buf  <= n_buf;
            end
        end
    end

endmodule

// File: rtl/sha256_fifo.sv
// Two-entry block queue between the front and the compression core.
module sha256_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  sha256_pkg::t_blk i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output sha256_pkg::t_blk o_data
);

    sha256_pkg::t_blk r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// File: rtl/sha256_core.sv
// Compression core: 64 rounds one per cycle, hash update, digest output.
module sha256_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  sha256_pkg::t_blk i_blk,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [31:0]      o_word,
    output logic [2:0]       o_index,
    output logic             o_last
);

    sha256_pkg::t_core_st r_st, n_st;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_rnd;
    logic [2:0]  r_idx;
    logic        r_final;
    logic [31:0] wt;
    logic [31:0] wn;
    logic [31:0] t1;
    logic [31:0] t2;
    logic        load;

    assign load = (r_st == sha256_pkg::ST_IDLE) && i_valid;

    // Next state.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            sha256_pkg::ST_IDLE:  if (i_valid) n_st = sha256_pkg::ST_ROUND;
            sha256_pkg::ST_ROUND: if (r_rnd == 6'd63) n_st = sha256_pkg::ST_ADD;
            sha256_pkg::ST_ADD:   n_st = r_final ? sha256_pkg::ST_EMIT : sha256_pkg::ST_IDLE;
            sha256_pkg::ST_EMIT:  if (i_ready && r_idx == 3'd7) n_st = sha256_pkg::ST_IDLE;
            default:              n_st = sha256_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_ready = (r_st == sha256_pkg::ST_IDLE);
        o_valid = (r_st == sha256_pkg::ST_EMIT);
        o_word  = r_h[r_idx];
        o_index = r_idx;
        o_last  = (r_idx == 3'd7);
    end

    // Schedule word and round sums.
    always_comb begin
        logic [31:0] w2, w15, s0, s1;
        w2  = r_w[14];
        w15 = r_w[1];
        s1  = sha256_pkg::ror(w2, 17) ^ sha256_pkg::ror(w2, 19) ^ (w2 >> 10);
        s0  = sha256_pkg::ror(w15, 7) ^ sha256_pkg::ror(w15, 18) ^ (w15 >> 3);
        wn  = s1 + r_w[9] + s0 + r_w[0];
        wt  = r_w[0];
        t1  = r_v[7] + (sha256_pkg::ror(r_v[4], 6) ^ sha256_pkg::ror(r_v[4], 11)
              ^ sha256_pkg::ror(r_v[4], 25)) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + sha256_pkg::K_TABLE[r_rnd] + wt;
        t2  = (sha256_pkg::ror(r_v[0], 2) ^ sha256_pkg::ror(r_v[0], 13)
              ^ sha256_pkg::ror(r_v[0], 22))
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= sha256_pkg::ST_IDLE;
            r_rnd <= '0;
            r_idx <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::H_INIT[i];
        end else begin
            r_st <= n_st;
            if (r_st == sha256_pkg::ST_ROUND) r_rnd <= r_rnd + 6'd1;
            if (r_st == sha256_pkg::ST_ADD) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
            if (r_st == sha256_pkg::ST_EMIT && i_ready) begin
                r_idx <= r_idx + 3'd1;
                if (r_idx == 3'd7) begin
                    for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::H_INIT[i];
                end
            end
        end
    end

    // Working variables and rolling schedule window.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_final <= i_blk.final_blk;
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            for (int i = 0; i < 16; i++) r_w[i] <= i_blk.block[511 - 32*i -: 32];
        end else if (r_st == sha256_pkg::ST_ROUND) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= wn;
        end
    end

endmodule

// File: rtl/sha256_message_hash.sv
// Top level of the byte-streaming SHA-256 hash.
// Bytes one per cycle, except while the front holds a filled block to hand on, and longer while the queue is full.
// The core takes each 64-byte block through load, 64 rounds and hash add.
// First digest word valid once the final block (one or two after the last byte) is hashed,
// later while an earlier block holds the core; then one word per ready cycle.
// Synchronous active-low reset returns the hash to its initial value.
module sha256_message_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast
);

    sha256_pkg::t_blk f_blk;
    sha256_pkg::t_blk q_blk;
    logic f_valid, f_ready, q_valid, q_ready;
    logic [31:0] word;
    logic [2:0]  idx;

    sha256_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_byte(s_axis_tdata), .i_byte_valid(s_axis_tuser), .i_last(s_axis_tlast),
        .o_blk_valid(f_valid), .i_blk_ready(f_ready), .o_blk(f_blk)
    );

    sha256_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready), .i_data(f_blk),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_blk)
    );

    sha256_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_blk(q_blk),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_word(word), .o_index(idx), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, idx, word};

endmodule
